@@ rtl/core/directory_name_table_macros.svh @@
// Assertion macros for the directory name table checker.
// Depends on nothing; include it by its bare file name.
`ifndef DIRECTORY_NAME_TABLE_MACROS_SVH
`define DIRECTORY_NAME_TABLE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DNT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("directory name table check failed");

// Clocked assertion that also holds during reset.
`define DNT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("directory name table check failed");

`endif

@@ rtl/core/dnt_pkg.sv @@
// Package for the directory name table: field widths, command and status codes.
// Used by the top level and by its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dnt_pkg;

  // Fixed field widths of a request and of a result.
  localparam int unsigned NameW   = 64;
  localparam int unsigned SectorW = 10;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned NameBytesMax = NameW / 8;

  // Command codes of a request.
  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

`default_nettype wire

@@ rtl/core/dnt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Holds the name and sector of every directory slot; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dnt_ram #(
  parameter int unsigned Width = 74,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port; the contents need no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/directory_name_table.sv @@
// Directory name table: request and result channels around a slot scanner.
// Uses dnt_pkg for widths and codes and dnt_ram for the name and sector store.
//
// Usage
//   A request (command, name key, new sector) is taken on the input channel
//   when in_valid_i and in_ready_o are both high. Find returns the sector and
//   slot of the matching entry, add fills the lowest free slot unless the name
//   is already present or the table is full, and remove frees the matching
//   slot. Exactly one result leaves on the output channel for each request.
//   The request is taken in the idle state, every slot is then scanned, and a
//   commit step writes the result register; ready returns in the same cycle
//   as the result becomes valid, so the block takes no new request until the
//   previous one has committed. The scan reads one slot a cycle through the
//   registered read port of the store and one name comparator.
//   The result is held in an output register, so a new request is taken while
//   an older result still waits; a finished request waits in its commit step
//   while the receiver stalls and the previous result is not yet taken.
//   Reset clears all valid marks at once and the output channel; the table is
//   empty and ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module directory_name_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned NAME_BYTES    = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire dnt_pkg::cmd_e                 command_i,
  input  wire logic [dnt_pkg::NameW-1:0]     name_key_i,
  input  wire logic [dnt_pkg::SectorW-1:0]   new_sector_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output dnt_pkg::status_e                   status_o,
  output logic      [dnt_pkg::SectorW-1:0]   found_sector_o,
  output logic      [dnt_pkg::SlotW-1:0]     slot_index_o
);

  import dnt_pkg::*;

  localparam int unsigned IdxW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EntryW = NameW + SectorW;
  localparam logic [CntW-1:0] CntEnd = CntW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_e;

  // Keeps the bytes of a name up to its first zero byte and below NAME_BYTES.
  function automatic logic [NameW-1:0] norm_name(logic [NameW-1:0] key);
    logic [NameW-1:0] res;
    logic             keep;
    res  = '0;
    keep = 1'b1;
    for (int b = 0; b < NameBytesMax; b++) begin
      if (key[8*b +: 8] == 8'h00 || b >= NAME_BYTES) begin
        keep = 1'b0;
      end
      if (keep) begin
        res[8*b +: 8] = key[8*b +: 8];
      end
    end
    return res;
  endfunction

  state_e                    state_q, state_d;
  logic [TABLE_ENTRIES-1:0]  valid_q, valid_d;
  cmd_e                      cmd_q, cmd_d;
  logic [NameW-1:0]          name_q, name_d;
  logic [SectorW-1:0]        sector_q, sector_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      chk_vld_q, chk_vld_d;
  logic                      chk_ent_q, chk_ent_d;
  logic [IdxW-1:0]           chk_idx_q, chk_idx_d;
  logic                      hit_q, hit_d;
  logic [IdxW-1:0]           hit_idx_q, hit_idx_d;
  logic [SectorW-1:0]        hit_sec_q, hit_sec_d;
  logic                      free_q, free_d;
  logic [IdxW-1:0]           free_idx_q, free_idx_d;
  logic                      out_valid_q, out_valid_d;
  status_e                   status_q, status_d;
  logic [SectorW-1:0]        found_q, found_d;
  logic [SlotW-1:0]          slot_q, slot_d;

  logic [IdxW-1:0]           rd_idx;
  logic [EntryW-1:0]         rd_data;
  logic                      ram_we;
  logic                      out_free;

  assign rd_idx   = cnt_q[IdxW-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  // Name and sector store, one entry per slot.
  dnt_ram #(
    .Width (EntryW),
    .Depth (TABLE_ENTRIES),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i ({name_q, sector_q}),
    .raddr_i (rd_idx),
    .rdata_o (rd_data)
  );

  // Sequencer: take a request, scan every slot, then commit and report.
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    cmd_d       = cmd_q;
    name_d      = name_q;
    sector_d    = sector_q;
    cnt_d       = cnt_q;
    chk_vld_d   = 1'b0;
    chk_ent_d   = chk_ent_q;
    chk_idx_d   = chk_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_sec_d   = hit_sec_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    found_d     = found_q;
    slot_d      = slot_q;
    ram_we      = 1'b0;
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d    = command_i;
          name_d   = norm_name(name_key_i);
          sector_d = new_sector_i;
          cnt_d    = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
          state_d  = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the read of the next slot and note the lowest free one.
        if (cnt_q != CntEnd) begin
          chk_vld_d = 1'b1;
          chk_ent_d = valid_q[rd_idx];
          chk_idx_d = rd_idx;
          cnt_d     = cnt_q + CntW'(1);
          if (!valid_q[rd_idx] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx;
          end
        end else begin
          state_d = S_EXEC;
        end
        // Compare the slot read in the previous cycle.
        if (chk_vld_q && chk_ent_q && !hit_q &&
            rd_data[EntryW-1:SectorW] == name_q) begin
          hit_d     = 1'b1;
          hit_idx_d = chk_idx_q;
          hit_sec_d = rd_data[SectorW-1:0];
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = ST_NOT_FOUND;
          found_d     = '0;
          slot_d      = '0;
          case (cmd_q)
            CMD_FIND: begin
              if (hit_q) begin
                status_d = ST_OK;
                found_d  = hit_sec_q;
                slot_d   = SlotW'(hit_idx_q);
              end
            end
            CMD_ADD: begin
              if (hit_q) begin
                status_d = ST_PRESENT;
              end else if (free_q) begin
                status_d            = ST_OK;
                slot_d              = SlotW'(free_idx_q);
                ram_we              = 1'b1;
                valid_d[free_idx_q] = 1'b1;
              end else begin
                status_d = ST_FULL;
              end
            end
            CMD_REMOVE: begin
              if (hit_q) begin
                status_d           = ST_OK;
                slot_d             = SlotW'(hit_idx_q);
                valid_d[hit_idx_q] = 1'b0;
              end
            end
            default: begin
              status_d = ST_NOT_FOUND;
            end
          endcase
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, valid marks, working registers and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    name_q     <= name_d;
    sector_q   <= sector_d;
    chk_ent_q  <= chk_ent_d;
    chk_idx_q  <= chk_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_sec_q  <= hit_sec_d;
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    found_q    <= found_d;
    slot_q     <= slot_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_sector_o = found_q;
  assign slot_index_o   = slot_q;

endmodule

`default_nettype wire

@@ rtl/core/dnt_checker.sv @@
// Port-level checks for the directory name table, bound to its top level.
// Depends on dnt_pkg and on the macros in directory_name_table_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "directory_name_table_macros.svh"

module dnt_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire dnt_pkg::status_e              status_o,
  input wire logic [dnt_pkg::SectorW-1:0]   found_sector_o,
  input wire logic [dnt_pkg::SlotW-1:0]     slot_index_o
);

  import dnt_pkg::*;

  // A waiting result holds its value until it is taken.
  `DNT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(found_sector_o) && $stable(slot_index_o))

  // One request at a time: the block is busy right after taking one.
  `DNT_ASSERT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // A failed request reports no slot and no sector.
  `DNT_ASSERT(a_fail_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK |-> found_sector_o == '0 && slot_index_o == '0)

  // A new result is only raised at the end of a busy period.
  `DNT_ASSERT(a_result_after_busy, clk_i, rst_ni, $rose(out_valid_o) |-> !$past(in_ready_o))

endmodule

bind directory_name_table dnt_checker u_dnt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .found_sector_o (found_sector_o),
  .slot_index_o   (slot_index_o)
);

`default_nettype wire

@@ tb/dnt_checker.sv @@
// Scoreboard for the directory name table: watches both channels, keeps its own copy of the table.
// Depends on dnt_pkg for widths and codes; hands a mismatch count and the outstanding count upward.
`timescale 1ns / 1ps

module dnt_scoreboard #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned NAME_BYTES    = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  dnt_pkg::cmd_e                 command_i,
  input  logic [dnt_pkg::NameW-1:0]     name_key_i,
  input  logic [dnt_pkg::SectorW-1:0]   new_sector_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  dnt_pkg::status_e              status_i,
  input  logic [dnt_pkg::SectorW-1:0]   found_sector_i,
  input  logic [dnt_pkg::SlotW-1:0]     slot_index_i,
  output int                            fail_count_o,
  output int                            replies_pending_o
);

  import dnt_pkg::*;

  localparam int NoSlot = -1;

  typedef struct packed {
    status_e             status;
    logic [SectorW-1:0]  sector;
    logic [SlotW-1:0]    slot;
  } dir_reply_t;

  // Shadow copy of the directory.
  logic               slot_used   [TABLE_ENTRIES];
  logic [NameW-1:0]   slot_name   [TABLE_ENTRIES];
  logic [SectorW-1:0] slot_sector [TABLE_ENTRIES];

  dir_reply_t replies_q [$];
  int         mismatches;
  int         outstanding;

  assign fail_count_o      = mismatches;
  assign replies_pending_o = outstanding;

  // A name stops at its first zero byte and at NAME_BYTES bytes.
  function automatic logic [NameW-1:0] canonical_name(logic [NameW-1:0] key);
    logic [NameW-1:0] name;
    bit               ended;
    name  = '0;
    ended = 1'b0;
    for (int i = 0; i < NAME_BYTES && i < NameBytesMax; i++) begin
      if (key[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) name[8*i +: 8] = key[8*i +: 8];
    end
    return name;
  endfunction

  // Lowest valid slot holding the name, or NoSlot.
  function automatic int find_slot(logic [NameW-1:0] name);
    int hit;
    hit = NoSlot;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit == NoSlot && slot_used[i] && slot_name[i] == name) hit = i;
    end
    return hit;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t ns: %s got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Updates the shadow table for one request and queues the reply it should give.
  task automatic apply_request(cmd_e cmd, logic [NameW-1:0] key, logic [SectorW-1:0] sector);
    dir_reply_t       reply;
    logic [NameW-1:0] name;
    int               hit;
    int               free_slot;
    name         = canonical_name(key);
    hit          = find_slot(name);
    reply.status = ST_NOT_FOUND;
    reply.sector = '0;
    reply.slot   = '0;
    case (cmd)
      CMD_FIND: begin
        if (hit != NoSlot) begin
          reply.status = ST_OK;
          reply.sector = slot_sector[hit];
          reply.slot   = SlotW'(hit);
        end
      end
      CMD_ADD: begin
        if (hit != NoSlot) begin
          reply.status = ST_PRESENT;
        end else begin
          free_slot = NoSlot;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (free_slot == NoSlot && !slot_used[i]) free_slot = i;
          end
          if (free_slot == NoSlot) begin
            reply.status = ST_FULL;
          end else begin
            slot_used[free_slot]   = 1'b1;
            slot_name[free_slot]   = name;
            slot_sector[free_slot] = sector;
            reply.status           = ST_OK;
            reply.slot             = SlotW'(free_slot);
          end
        end
      end
      CMD_REMOVE: begin
        if (hit != NoSlot) begin
          slot_used[hit] = 1'b0;
          reply.status   = ST_OK;
          reply.slot     = SlotW'(hit);
        end
      end
      default: begin
        // The reserved command leaves the table alone.
      end
    endcase
    replies_q.push_back(reply);
  endtask

  // Compares one taken result with the oldest reply still owed.
  task automatic check_reply();
    dir_reply_t want;
    if (replies_q.size() == 0) begin
      report_mismatch("result with no request outstanding", status_i, 0);
      return;
    end
    want = replies_q.pop_front();
    if (status_i !== want.status) report_mismatch("status", status_i, want.status);
    if (found_sector_i !== want.sector)
      report_mismatch("found_sector", found_sector_i, want.sector);
    if (slot_index_i !== want.slot) report_mismatch("slot_index", slot_index_i, want.slot);
  endtask

  // The result taken at an edge belongs to an older request, so it is checked first.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      replies_q.delete();
      outstanding = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_reply();
      if (in_valid_i && in_ready_i) apply_request(command_i, name_key_i, new_sector_i);
      outstanding = replies_q.size();
    end
  end

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

endmodule

@@ tb/tb_directory_name_table.sv @@
// Top of the directory name table testbench: clock, reset, request and result traffic, verdict.
// Depends on dnt_pkg, the directory_name_table block and the dnt_scoreboard module.
`timescale 1ns / 1ps

module tb_directory_name_table;

  import dnt_pkg::*;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned NameBytes    = 8;
  localparam int          PoolSize     = 24;
  localparam int          RandomItems  = 1200;
  localparam int          CalmItems    = 150;
  localparam int          SegmentItems = 150;
  localparam int          DrainPauseAt = 700;
  localparam int          HoldAfter    = 300;
  localparam int          HoldCycles   = 300;
  localparam int          TailCycles   = 40;
  localparam int unsigned CycleLimit   = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  cmd_e               command;
  logic [NameW-1:0]   name_key;
  logic [SectorW-1:0] new_sector;
  logic               out_valid;
  logic               out_ready;
  status_e            status;
  logic [SectorW-1:0] found_sector;
  logic [SlotW-1:0]   slot_index;

  int          fail_count;
  int          replies_pending;
  logic        in_taken;
  int          results_taken;
  int unsigned cycle_count;

  // Shared traffic shaping: chance of an idle burst, and a calm tail with none.
  int unsigned idle_pct;
  bit          calm;

  // Names that well-formed traffic draws from, with their lengths in bytes.
  logic [NameW-1:0] name_pool [PoolSize];
  int unsigned      name_len  [PoolSize];

  directory_name_table #(
    .TABLE_ENTRIES (TableEntries),
    .NAME_BYTES    (NameBytes)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .name_key_i     (name_key),
    .new_sector_i   (new_sector),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .found_sector_o (found_sector),
    .slot_index_o   (slot_index)
  );

  dnt_scoreboard #(
    .TABLE_ENTRIES (TableEntries),
    .NAME_BYTES    (NameBytes)
  ) u_scoreboard (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .command_i         (command),
    .name_key_i        (name_key),
    .new_sector_i      (new_sector),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .status_i          (status),
    .found_sector_i    (found_sector),
    .slot_index_i      (slot_index),
    .fail_count_o      (fail_count),
    .replies_pending_o (replies_pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshake flags sampled at the rising edge, read by the drivers at the falling edge.
  always_ff @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_taken      <= 1'b0;
      results_taken <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) results_taken <= results_taken + 1;
    end
  end

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  // A name of the given length made of non-zero bytes.
  function automatic logic [NameW-1:0] fresh_name(int unsigned len);
    logic [NameW-1:0] key;
    key = '0;
    for (int i = 0; i < NameBytesMax; i++) begin
      if (i < len) key[8*i +: 8] = 8'($urandom_range(1, 255));
    end
    return key;
  endfunction

  // The same name spelt with random bytes past its terminating zero.
  function automatic logic [NameW-1:0] alias_of(logic [NameW-1:0] key, int unsigned len);
    logic [NameW-1:0] spelt;
    spelt = key;
    for (int i = 0; i < NameBytesMax; i++) begin
      if (i > len) spelt[8*i +: 8] = 8'($urandom);
    end
    return spelt;
  endfunction

  // Offers one request, after an optional idle burst, and waits until it is taken.
  task automatic send_request(cmd_e cmd, logic [NameW-1:0] key, logic [SectorW-1:0] sector);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    name_key   <= key;
    new_sector <= sector;
    do @(negedge clk); while (!in_taken);
  endtask

  // Holds back new requests until every owed result has come out.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(negedge clk); while (replies_pending != 0);
  endtask

  // Result side: random stalls, and one long hold-off so the block backs up.
  initial begin : receiver
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_taken >= HoldAfter) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else if (rst_n && !calm && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Request side and verdict.
  initial begin : stimulus
    cmd_e             cmd;
    logic [NameW-1:0] key;
    int unsigned      k;
    int unsigned      pick;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    command    = CMD_FIND;
    name_key   = '0;
    new_sector = '0;
    calm       = 1'b0;
    idle_pct   = 25;

    // The pool starts with the names the directed part leaves in the table.
    name_pool[0] = '0;
    name_len[0]  = 0;
    name_pool[1] = '1;
    name_len[1]  = NameBytesMax;
    for (int i = 2; i < 16; i++) begin
      name_pool[i] = {56'h5A_5A5A_5A5A_5A5A, 8'(i)};
      name_len[i]  = NameBytesMax;
    end
    for (int i = 16; i < PoolSize; i++) begin
      name_len[i]  = $urandom_range(0, NameBytesMax);
      name_pool[i] = fresh_name(name_len[i]);
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, empty and all-ones names, truncation, duplicates, reserved code.
    send_request(CMD_FIND, '0, '0);
    send_request(CMD_ADD, name_pool[0], '0);
    send_request(CMD_ADD, name_pool[1], '1);
    send_request(CMD_ADD, 64'h0000_0000_0000_0041, 10'd5);
    send_request(CMD_FIND, 64'hFFFF_FFFF_FFFF_0041, '1);
    send_request(CMD_ADD, 64'h0000_0000_0012_0041, 10'd9);
    send_request(CMD_FIND, 64'h0000_0000_0000_FF00, '0);
    send_request(CMD_RSVD, '1, '1);
    send_request(CMD_REMOVE, 64'h0000_0000_0000_0041, '0);
    send_request(CMD_REMOVE, 64'h0000_0000_0000_0041, '0);
    send_request(CMD_FIND, 64'h0000_0000_0000_0041, '0);
    // Fill the table, then one more add must find it full.
    for (int i = 2; i < 16; i++) begin
      send_request(CMD_ADD, name_pool[i], 10'($urandom_range(0, 1023)));
    end
    send_request(CMD_ADD, 64'h0000_0000_0000_0042, 10'd7);
    send_request(CMD_FIND, name_pool[1], '0);

    // Random traffic, mostly over a small pool of names so that hits and a full table occur.
    for (int n = 0; n < RandomItems; n++) begin
      if (n % SegmentItems == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 20;
          default: idle_pct = 50;
        endcase
      end
      calm = (n >= RandomItems - CalmItems);
      if (n == DrainPauseAt) wait_for_replies();

      k = $urandom_range(0, PoolSize - 1);
      if ($urandom_range(0, 49) == 0) begin
        name_len[k]  = $urandom_range(0, NameBytesMax);
        name_pool[k] = fresh_name(name_len[k]);
      end
      key  = $urandom_range(0, 1) ? alias_of(name_pool[k], name_len[k]) : name_pool[k];
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        cmd = CMD_ADD;
      end else if (pick < 70) begin
        cmd = CMD_FIND;
      end else if (pick < 90) begin
        cmd = CMD_REMOVE;
      end else if (pick < 95) begin
        cmd = CMD_RSVD;
      end else begin
        cmd = cmd_e'($urandom_range(0, 2));
        key = {$urandom, $urandom};
      end
      send_request(cmd, key, 10'($urandom_range(0, 1023)));
    end

    // Let every owed result come out, then a few more cycles for anything stray.
    in_valid <= 1'b0;
    do @(negedge clk); while (replies_pending != 0);
    repeat (TailCycles) @(negedge clk);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/dnt_pkg.sv
rtl/core/dnt_ram.sv
rtl/core/directory_name_table.sv
rtl/core/dnt_checker.sv
tb/dnt_checker.sv
tb/tb_directory_name_table.sv
